// File: hw/rtl/rtyv_pkg.sv
`default_nettype none

package rtyv_pkg;

	localparam int DIM_REG_W = 13;
	localparam int PIX_W     = 8;

	// register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	localparam logic [DIM_REG_W-1:0] WIDTH_RST  = 13'd1920;
	localparam logic [DIM_REG_W-1:0] HEIGHT_RST = 13'd1080;

	// chroma plane codes
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CB   = 2'd1;
	localparam logic [1:0] KIND_CR   = 2'd2;

	// bt.601 weights, 8 fractional bits
	localparam logic signed [17:0] C_Y_R  = 18'sd66;
	localparam logic signed [17:0] C_Y_G  = 18'sd129;
	localparam logic signed [17:0] C_Y_B  = 18'sd25;
	localparam logic signed [17:0] C_CB_R = 18'sd38;
	localparam logic signed [17:0] C_CB_G = 18'sd74;
	localparam logic signed [17:0] C_CB_B = 18'sd112;
	localparam logic signed [17:0] C_CR_R = 18'sd112;
	localparam logic signed [17:0] C_CR_G = 18'sd94;
	localparam logic signed [17:0] C_CR_B = 18'sd18;
	localparam logic signed [17:0] C_RND  = 18'sd128;
	localparam logic [PIX_W-1:0]   Y_OFS  = 8'd16;
	localparam logic [PIX_W-1:0]   C_OFS  = 8'd128;

	typedef struct packed {
		logic [1:0] kind;
		logic       frame_end;
	} pos_tag_t;

endpackage

`default_nettype wire

// File: hw/rtl/rtyv_pos.sv
`default_nettype none

module rtyv_pos import rtyv_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_we,
	input  wire                  cfg_index,
	input  wire [DIM_REG_W-1:0]  cfg_data,
	input  wire                  step,
	output pos_tag_t             tag
);

	localparam int CW = $clog2(MAX_DIM);

	// effective size minus one: zero counts as one, large values clamp
	function automatic logic [CW-1:0] eff_last(input logic [DIM_REG_W-1:0] v);
		logic [CW-1:0] r;
		if (v == '0)
			r = '0;
		else if (32'(v) > 32'(MAX_DIM))
			r = CW'(MAX_DIM - 1);
		else
			r = CW'(v - 13'd1);
		return r;
	endfunction

	logic [DIM_REG_W-1:0] width_q;
	logic [DIM_REG_W-1:0] height_q;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        row_q;
	logic [CW-1:0]        w_last;
	logic [CW-1:0]        h_last;
	logic                 last_col;
	logic [DIM_REG_W-1:0] new_height;

	assign w_last     = eff_last(width_q);
	assign h_last     = eff_last(height_q);
	assign last_col   = col_q >= w_last;
	assign new_height = (cfg_index == CFG_HEIGHT) ? cfg_data : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			col_q    <= '0;
			row_q    <= eff_last(HEIGHT_RST);
		end else if (cfg_we) begin
			if (cfg_index == CFG_WIDTH)
				width_q <= cfg_data;
			else
				height_q <= cfg_data;
			// any write restarts the frame
			col_q <= '0;
			row_q <= eff_last(new_height);
		end else if (step) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= (row_q == '0) ? h_last : row_q - 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_comb begin
		if (col_q[0])
			tag.kind = KIND_NONE;
		else if (row_q[0])
			tag.kind = KIND_CR;
		else
			tag.kind = KIND_CB;
		tag.frame_end = last_col && (row_q == '0);
	end

endmodule

`default_nettype wire

// File: hw/rtl/rtyv_csc.sv
`default_nettype none

module rtyv_csc import rtyv_pkg::*; (
	input  wire [PIX_W-1:0]  blue,
	input  wire [PIX_W-1:0]  green,
	input  wire [PIX_W-1:0]  red,
	input  wire [1:0]        kind,
	output logic [PIX_W-1:0] luma,
	output logic [PIX_W-1:0] chroma
);

	logic signed [17:0] b_s;
	logic signed [17:0] g_s;
	logic signed [17:0] r_s;
	logic signed [17:0] sum_y;
	logic signed [17:0] sum_cb;
	logic signed [17:0] sum_cr;

	assign b_s = signed'({10'b0, blue});
	assign g_s = signed'({10'b0, green});
	assign r_s = signed'({10'b0, red});

	assign sum_y  = C_Y_R * r_s + C_Y_G * g_s + C_Y_B * b_s + C_RND;
	assign sum_cb = C_CB_B * b_s - C_CB_R * r_s - C_CB_G * g_s + C_RND;
	assign sum_cr = C_CR_R * r_s - C_CR_G * g_s - C_CR_B * b_s + C_RND;

	// floor shift by 8 then mod 256 is just bits 15:8 of the two's complement sum
	assign luma = sum_y[15:8] + Y_OFS;

	always_comb begin
		case (kind)
			KIND_CB: chroma = sum_cb[15:8] + C_OFS;
			KIND_CR: chroma = sum_cr[15:8] + C_OFS;
			default: chroma = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_to_yuv420_pixel_stream_unit.sv
// an item goes from the input register to the result register, where it is offered to the receiver
// throughput: one item per cycle while the receiver does not stall, set by the single input and result register pair
// a full result register with stall high holds the next item in the input register
// reset: frame size returns to 1920 x 1080, counters to column 0 with the row counter at height minus one,
// both pipeline stages empty
`default_nettype none

module rgb_to_yuv420_pixel_stream_unit import rtyv_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire [DIM_REG_W-1:0] cfg_data,
	input  wire                 pix_valid,
	output logic                pix_stall,
	input  wire [PIX_W-1:0]     blue,
	input  wire [PIX_W-1:0]     green,
	input  wire [PIX_W-1:0]     red,
	output logic                res_valid,
	input  wire                 res_stall,
	output logic [PIX_W-1:0]    luma,
	output logic [PIX_W-1:0]    chroma,
	output logic [1:0]          chroma_kind,
	output logic                frame_end
);

	logic             adv_s1;
	logic             adv_s2;
	logic             accept;
	pos_tag_t         tag;

	logic             valid_s1;
	logic [PIX_W-1:0] blue_s1;
	logic [PIX_W-1:0] green_s1;
	logic [PIX_W-1:0] red_s1;
	pos_tag_t         tag_s1;

	logic             valid_s2;
	logic [PIX_W-1:0] luma_s2;
	logic [PIX_W-1:0] chroma_s2;
	logic [1:0]       kind_s2;
	logic             frame_end_s2;

	logic [PIX_W-1:0] luma_c;
	logic [PIX_W-1:0] chroma_c;

	assign adv_s2    = !valid_s2 || !res_stall;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pix_stall = !adv_s1;
	assign accept    = pix_valid && adv_s1;

	rtyv_pos #(
		.MAX_DIM (MAX_DIM)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.tag       (tag)
	);

	rtyv_csc u_csc (
		.blue   (blue_s1),
		.green  (green_s1),
		.red    (red_s1),
		.kind   (tag_s1.kind),
		.luma   (luma_c),
		.chroma (chroma_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= pix_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blue_s1  <= blue;
			green_s1 <= green;
			red_s1   <= red;
			tag_s1   <= tag;
		end
		if (adv_s2 && valid_s1) begin
			luma_s2      <= luma_c;
			chroma_s2    <= chroma_c;
			kind_s2      <= tag_s1.kind;
			frame_end_s2 <= tag_s1.frame_end;
		end
	end

	assign res_valid   = valid_s2;
	assign luma        = luma_s2;
	assign chroma      = chroma_s2;
	assign chroma_kind = kind_s2;
	assign frame_end   = frame_end_s2;

endmodule

`default_nettype wire

// File: dv/rgb_to_yuv420_pixel_stream_unit_tb.sv
`default_nettype none

module rgb_to_yuv420_pixel_stream_unit_tb;
	import rtyv_pkg::*;

	localparam int MAX_DIM       = 4096;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma;
		logic [1:0]       kind;
		logic             frame_end;
	} yuv_sample_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_index = CFG_WIDTH;
	logic [DIM_REG_W-1:0] cfg_data  = '0;
	logic                 pix_valid = 1'b0;
	logic                 pix_stall;
	logic [PIX_W-1:0]     blue      = '0;
	logic [PIX_W-1:0]     green     = '0;
	logic [PIX_W-1:0]     red       = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [PIX_W-1:0]     luma;
	logic [PIX_W-1:0]     chroma;
	logic [1:0]           chroma_kind;
	logic                 frame_end;

	yuv_sample_t pending_samples[$];
	int mismatches    = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len      = 0;
	int quiet_cycles  = 0;

	// predicted frame geometry and scan position
	logic [DIM_REG_W-1:0] width_reg;
	logic [DIM_REG_W-1:0] height_reg;
	int col_pos;
	int row_pos;

	rgb_to_yuv420_pixel_stream_unit #(
		.MAX_DIM(MAX_DIM)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.blue(blue),
		.green(green),
		.red(red),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.luma(luma),
		.chroma(chroma),
		.chroma_kind(chroma_kind),
		.frame_end(frame_end)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int eff_dim(logic [DIM_REG_W-1:0] v);
		if (v == 0) return 1;
		if (int'(v) > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic void restart_frame();
		col_pos = 0;
		row_pos = eff_dim(height_reg) - 1;
	endfunction

	// (sum >> 8) + offset, floor shift, wrapped to 8 bits
	function automatic logic [PIX_W-1:0] scale_sum(int sum, int ofs);
		int v;
		v = (sum >>> 8) + ofs;
		return v[PIX_W-1:0];
	endfunction

	function automatic yuv_sample_t next_yuv_sample(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] r);
		int bi;
		int gi;
		int ri;
		bit last_col;
		yuv_sample_t s;
		bi = int'(b);
		gi = int'(g);
		ri = int'(r);
		last_col = col_pos >= eff_dim(width_reg) - 1;
		s.luma = scale_sum(66 * ri + 129 * gi + 25 * bi + 128, 16);
		s.chroma = '0;
		s.kind = KIND_NONE;
		if (col_pos % 2 == 0) begin
			if (row_pos % 2 == 0) begin
				s.chroma = scale_sum(-38 * ri - 74 * gi + 112 * bi + 128, 128);
				s.kind = KIND_CB;
			end else begin
				s.chroma = scale_sum(112 * ri - 94 * gi - 18 * bi + 128, 128);
				s.kind = KIND_CR;
			end
		end
		s.frame_end = last_col && row_pos == 0;
		if (last_col) begin
			col_pos = 0;
			row_pos = (row_pos == 0) ? eff_dim(height_reg) - 1 : row_pos - 1;
		end else begin
			col_pos++;
		end
		return s;
	endfunction

	function automatic logic [PIX_W-1:0] rand_component();
		logic [PIX_W-1:0] v;
		if ($urandom_range(7) == 0) v = $urandom_range(1) ? 8'hff : 8'h00;
		else v = PIX_W'($urandom_range(255));
		return v;
	endfunction

	function automatic logic [DIM_REG_W-1:0] pick_frame_dim();
		int roll;
		roll = $urandom_range(99);
		if (roll < 65) return DIM_REG_W'(2 * $urandom_range(1, 6));
		if (roll < 80) return DIM_REG_W'(2 * $urandom_range(0, 7) + 1);
		if (roll < 85) return '0;
		if (roll < 90) return DIM_REG_W'($urandom_range(13, 64));
		case ($urandom_range(3))
			0: return DIM_REG_W'(MAX_DIM);
			1: return DIM_REG_W'(MAX_DIM + 1);
			2: return 13'd8191;
			default: return DIM_REG_W'($urandom_range(8191));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	// called and returns at a falling edge; valid stays up for a following item
	task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
			input logic [PIX_W-1:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(negedge clk);
		end
		pix_valid <= 1'b1;
		blue <= b;
		green <= g;
		red <= r;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		pending_samples.push_back(next_yuv_sample(b, g, r));
		@(negedge clk);
	endtask

	task automatic send_random_pixel();
		send_pixel(rand_component(), rand_component(), rand_component());
	endtask

	task automatic wait_drained();
		pix_valid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [DIM_REG_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WIDTH) width_reg = val;
		else height_reg = val;
		restart_frame();
	endtask

	task automatic set_frame(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
	endtask

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_len > 0) begin
			res_stall <= 1'b1;
			hold_len = hold_len - 1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		yuv_sample_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch("item with nothing pending, luma", int'(luma), -1);
			end else begin
				want = pending_samples.pop_front();
				if (luma !== want.luma)
					report_mismatch("luma", int'(luma), int'(want.luma));
				if (chroma !== want.chroma)
					report_mismatch("chroma", int'(chroma), int'(want.chroma));
				if (chroma_kind !== want.kind)
					report_mismatch("chroma_kind", int'(chroma_kind), int'(want.kind));
				if (frame_end !== want.frame_end)
					report_mismatch("frame_end", int'(frame_end), int'(want.frame_end));
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// reset geometry: odd source row, so even columns carry Cr
	task automatic test_color_extremes();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'h00);
		send_pixel(8'h00, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'hff);
		send_pixel(8'h80, 8'h80, 8'h80);
		send_pixel(8'h01, 8'h02, 8'h03);
	endtask

	// smallest legal frame wraps after four items; zero sizes act as one
	task automatic test_small_frames();
		set_frame(13'd2, 13'd2);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'h00, 8'hff, 8'hff);
		set_frame(13'd0, 13'd0);
		send_pixel(8'hff, 8'h00, 8'hff);
		send_pixel(8'h00, 8'hff, 8'h00);
	endtask

	// a register write in mid row starts the frame over
	task automatic test_restart_mid_row();
		set_frame(13'd8, 13'd8191);
		repeat (3) send_random_pixel();
		write_reg(CFG_WIDTH, 13'd8);
		repeat (3) send_random_pixel();
		write_reg(CFG_HEIGHT, DIM_REG_W'(MAX_DIM + 1));
		repeat (2) send_random_pixel();
	endtask

	task automatic test_random_frames(input int items);
		logic [DIM_REG_W-1:0] w;
		logic [DIM_REG_W-1:0] h;
		int sent;
		int count;
		int area;
		sent = 0;
		while (sent < items) begin
			w = pick_frame_dim();
			h = pick_frame_dim();
			set_frame(w, h);
			area = eff_dim(w) * eff_dim(h);
			// one or two whole frames and up to three more items when small, otherwise a partial frame cut by the next write
			if (area <= 200) count = area * $urandom_range(1, 2) + $urandom_range(0, 3);
			else count = $urandom_range(1, 40);
			repeat (count) send_random_pixel();
			sent += count;
		end
	endtask

	// receiver holds off while items keep coming, so the input backs up
	task automatic test_backpressure();
		set_frame(13'd6, 13'd4);
		@(posedge clk);
		hold_len = HOLD_CYCLES;
		@(negedge clk);
		repeat (24) send_random_pixel();
		while (hold_len > 0) @(negedge clk);
	endtask

	task automatic test_sender_pause();
		set_frame(13'd4, 13'd6);
		repeat (12) send_random_pixel();
		wait_drained();
		repeat (12) send_random_pixel();
	endtask

	// widest and clamped sizes, the start of a row each
	task automatic test_widest_row();
		set_frame(DIM_REG_W'(MAX_DIM), 13'd1);
		repeat (20) send_random_pixel();
		set_frame(DIM_REG_W'(MAX_DIM), DIM_REG_W'(MAX_DIM));
		repeat (6) send_random_pixel();
		set_frame(13'd8191, 13'd8191);
		repeat (6) send_random_pixel();
	endtask

	initial begin
		width_reg = WIDTH_RST;
		height_reg = HEIGHT_RST;
		restart_frame();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 33;
		recv_idle_pct = 73;
		test_color_extremes();
		test_small_frames();
		test_restart_mid_row();
		test_random_frames(450);
		test_backpressure();

		send_idle_pct = 73;
		recv_idle_pct = 33;
		test_random_frames(450);
		test_sender_pause();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_frames(450);
		test_widest_row();

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
